### rtl/btk_pkg.sv
// Shared types and constants for the bounded sorted top-k table.
`timescale 1ns / 1ps

package btk_pkg;

   // Table depth and key width actually compared and stored
   localparam int MAX_ENTRIES = 8;
   localparam int KEY_BITS    = 16;

   // Fixed field widths of the item ports
   localparam int KEY_FIELD_W = 16;
   localparam int TAG_W       = 16;
   localparam int RANK_W      = 3;
   localparam int LIMIT_W     = 4;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int OUT_CNT_W   = 4;

   // Command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   // One stored entry
   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [TAG_W-1:0]    tag;
   } entry_type;

   // Per-cell control from the top level
   typedef struct packed {
      logic shift_en;   // insert accepted this cycle
      logic occ;        // cell holds a live entry
      logic read_sel;   // cell is the addressed rank of a read
      logic tail_sel;   // cell is last live entry and an eviction happens
   } cell_ctrl_type;

   // Key field view of a stored key
   function automatic logic [KEY_FIELD_W-1:0] key_to_field(input logic [KEY_BITS-1:0] k);
      return KEY_FIELD_W'(k);
   endfunction

endpackage

### rtl/bounded_sorted_top_k_insert.sv
// Top level of the bounded sorted top-k table: cell chain, count, limit and result register.
`timescale 1ns / 1ps

// Keeps up to csr_data key/tag entries (clamped to 1..8) in ascending key order;
// equal keys put the newest first. On an insert every cell compares its key with
// the new key in parallel and shifts in the same cycle, and the result of an insert
// or a read appears in the output register on the next cycle. A new item is taken every
// cycle as long as the result register is empty or being read out. Only the
// live entries (count) are visible; a read beyond the count returns zeros.
module bounded_sorted_top_k_insert (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [btk_pkg::LIMIT_W-1:0]      csr_data,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [btk_pkg::KEY_FIELD_W-1:0]  req_entry_key,
   input  logic [btk_pkg::TAG_W-1:0]        req_entry_tag,
   input  logic [btk_pkg::RANK_W-1:0]       req_read_rank,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [btk_pkg::OUT_CNT_W-1:0]    rsp_placed_rank,
   output logic                             rsp_kept,
   output logic                             rsp_evict_valid,
   output logic [btk_pkg::KEY_FIELD_W-1:0]  rsp_evict_key,
   output logic [btk_pkg::TAG_W-1:0]        rsp_evict_tag,
   output logic                             rsp_rank_valid,
   output logic [btk_pkg::KEY_FIELD_W-1:0]  rsp_rank_key,
   output logic [btk_pkg::TAG_W-1:0]        rsp_rank_tag,
   output logic [btk_pkg::OUT_CNT_W-1:0]    rsp_entry_count
);

   localparam int N  = btk_pkg::MAX_ENTRIES;
   localparam int CW = btk_pkg::CNT_W;

   logic [CW-1:0]                 cnt_ff;
   logic [CW-1:0]                 cnt_in;
   logic [btk_pkg::LIMIT_W-1:0]   lim_ff;
   logic [CW-1:0]                 eff_lim;

   logic                          accept;
   logic                          do_insert;
   logic                          is_read;
   logic                          evict;
   logic [btk_pkg::KEY_BITS-1:0]  new_key;
   logic [CW-1:0]                 pos;

   btk_pkg::cell_ctrl_type        ctrl   [N];
   btk_pkg::entry_type            carry  [N+1];
   btk_pkg::entry_type            rd_bus [N];
   btk_pkg::entry_type            ev_bus [N];
   logic [N-1:0]                  lt_vec;
   btk_pkg::entry_type            rd_ent;
   btk_pkg::entry_type            ev_ent;
   logic                          rd_hit;

   // Result register
   logic                              rsp_valid_ff;
   logic [btk_pkg::OUT_CNT_W-1:0]     placed_ff;
   logic                              kept_ff;
   logic                              ev_valid_ff;
   btk_pkg::entry_type                ev_ff;
   logic                              rk_valid_ff;
   btk_pkg::entry_type                rk_ff;
   logic [btk_pkg::OUT_CNT_W-1:0]     count_ff;

   // Handshakes
   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_read   = (req_cmd == btk_pkg::CMD_READ);
   assign do_insert = accept && (req_cmd == btk_pkg::CMD_INSERT);
   assign new_key   = btk_pkg::KEY_BITS'(req_entry_key);

   // Effective limit: zero acts as one, above depth acts as depth
   always_comb begin
      priority if (lim_ff == '0) begin
         eff_lim = CW'(1);
      end else if (32'(lim_ff) > 32'(N)) begin
         eff_lim = CW'(N);
      end else begin
         eff_lim = CW'(lim_ff);
      end
   end

   assign evict = (cnt_ff >= eff_lim);

   // Cell control
   always_comb begin
      for (int i = 0; i < N; i++) begin
         ctrl[i].shift_en = do_insert;
         ctrl[i].occ      = (CW'(i) < cnt_ff);
         ctrl[i].read_sel = (CW'(i) < cnt_ff) && (CW'(req_read_rank) == CW'(i));
         ctrl[i].tail_sel = evict && (CW'(i + 1) == cnt_ff);
      end
   end

   assign carry[0] = '{key: new_key, tag: req_entry_tag};

   // Insertion chain
   for (genvar g = 0; g < N; g++) begin : g_cell
      btk_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl[g]),
         .new_key   (new_key),
         .carry_in  (carry[g]),
         .carry_out (carry[g+1]),
         .lt        (lt_vec[g]),
         .rd_out    (rd_bus[g]),
         .ev_out    (ev_bus[g])
      );
   end

   // Insert rank and OR of the one-hot read and eviction buses
   always_comb begin
      pos    = '0;
      rd_ent = '0;
      ev_ent = '0;
      rd_hit = 1'b0;
      for (int i = 0; i < N; i++) begin
         pos    = pos + CW'(lt_vec[i]);
         rd_ent = rd_ent | rd_bus[i];
         ev_ent = ev_ent | ev_bus[i];
         rd_hit = rd_hit | ctrl[i].read_sel;
      end
   end

   assign cnt_in = evict ? cnt_ff : cnt_ff + CW'(1);

   // Table count and limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         lim_ff <= btk_pkg::LIMIT_W'(5);
      end else begin
         if (csr_valid && csr_ready) begin
            lim_ff <= csr_data;
         end
         if (do_insert) begin
            cnt_ff <= cnt_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (is_read) begin
            placed_ff   <= '0;
            kept_ff     <= 1'b0;
            ev_valid_ff <= 1'b0;
            ev_ff       <= '0;
            rk_valid_ff <= rd_hit;
            rk_ff       <= rd_ent;
            count_ff    <= btk_pkg::OUT_CNT_W'(cnt_ff);
         end else begin
            placed_ff   <= btk_pkg::OUT_CNT_W'(pos);
            kept_ff     <= !(evict && (pos == cnt_ff));
            ev_valid_ff <= evict;
            ev_ff       <= ev_ent;
            rk_valid_ff <= 1'b0;
            rk_ff       <= '0;
            count_ff    <= btk_pkg::OUT_CNT_W'(cnt_in);
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_placed_rank = placed_ff;
   assign rsp_kept        = kept_ff;
   assign rsp_evict_valid = ev_valid_ff;
   assign rsp_evict_key   = btk_pkg::key_to_field(ev_ff.key);
   assign rsp_evict_tag   = ev_ff.tag;
   assign rsp_rank_valid  = rk_valid_ff;
   assign rsp_rank_key    = btk_pkg::key_to_field(rk_ff.key);
   assign rsp_rank_tag    = rk_ff.tag;
   assign rsp_entry_count = count_ff;

endmodule

### rtl/btk_cell.sv
// One cell of the insertion chain: holds an entry and shifts it right on insert.
`timescale 1ns / 1ps

module btk_cell (
   input  logic                          clock,
   input  btk_pkg::cell_ctrl_type        ctrl,
   input  logic [btk_pkg::KEY_BITS-1:0]  new_key,
   input  btk_pkg::entry_type            carry_in,
   output btk_pkg::entry_type            carry_out,
   output logic                          lt,
   output btk_pkg::entry_type            rd_out,
   output btk_pkg::entry_type            ev_out
);

   btk_pkg::entry_type entry_ff;
   btk_pkg::entry_type entry_in;
   logic               ge;

   // New entry goes at or before this cell unless a live smaller key sits here
   assign lt = ctrl.occ && (entry_ff.key < new_key);
   assign ge = !lt;

   // Displaced entry moves on; a smaller stored entry lets the incoming one pass
   assign carry_out = ge ? entry_ff : carry_in;
   assign entry_in  = ge ? carry_in : entry_ff;

   // Read and eviction buses, zero when not selected
   assign rd_out = ctrl.read_sel ? entry_ff  : '0;
   assign ev_out = ctrl.tail_sel ? carry_out : '0;

   // Entry storage
   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         entry_ff <= entry_in;
      end
   end

endmodule

### rtl/btk_checker.sv
// Port-level checks for the bounded sorted top-k table, bound to the top level.
`timescale 1ns / 1ps

module btk_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [btk_pkg::OUT_CNT_W-1:0]    rsp_placed_rank,
   input logic                             rsp_kept,
   input logic                             rsp_evict_valid,
   input logic                             rsp_rank_valid,
   input logic [btk_pkg::OUT_CNT_W-1:0]    rsp_entry_count
);

   // Stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   // Count never exceeds the table depth
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_entry_count) <= 32'(btk_pkg::MAX_ENTRIES))
      else $error("entry count above depth");

   // An insert at a nonzero rank without eviction is always kept
   a_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evict_valid && rsp_placed_rank != '0 |-> rsp_kept)
      else $error("entry dropped without eviction");

   // A successful read sees a nonempty table and evicts nothing
   a_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rank_valid |-> rsp_entry_count != '0 && !rsp_evict_valid)
      else $error("inconsistent read result");

endmodule

bind bounded_sorted_top_k_insert btk_checker u_btk_checker (.*);

### dv/bounded_sorted_top_k_insert_tb.sv
// Self-checking testbench for the bounded sorted top-k table: directed and random traffic.
`timescale 1ns / 1ps

module bounded_sorted_top_k_insert_tb;

   localparam int KW    = btk_pkg::KEY_FIELD_W;
   localparam int TW    = btk_pkg::TAG_W;
   localparam int RW    = btk_pkg::RANK_W;
   localparam int LW    = btk_pkg::LIMIT_W;
   localparam int CW    = btk_pkg::OUT_CNT_W;
   localparam int DEPTH = btk_pkg::MAX_ENTRIES;

   // One result item as the block reports it
   typedef struct packed {
      logic [CW-1:0] placed_rank;
      logic          kept;
      logic          evict_valid;
      logic [KW-1:0] evict_key;
      logic [TW-1:0] evict_tag;
      logic          rank_valid;
      logic [KW-1:0] rank_key;
      logic [TW-1:0] rank_tag;
      logic [CW-1:0] entry_count;
   } topk_result_type;

   logic          clock;
   logic          reset;
   logic          csr_valid;
   logic          csr_ready;
   logic [LW-1:0] csr_data;
   logic          req_valid;
   logic          req_ready;
   logic          req_cmd;
   logic [KW-1:0] req_entry_key;
   logic [TW-1:0] req_entry_tag;
   logic [RW-1:0] req_read_rank;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [CW-1:0] rsp_placed_rank;
   logic          rsp_kept;
   logic          rsp_evict_valid;
   logic [KW-1:0] rsp_evict_key;
   logic [TW-1:0] rsp_evict_tag;
   logic          rsp_rank_valid;
   logic [KW-1:0] rsp_rank_key;
   logic [TW-1:0] rsp_rank_tag;
   logic [CW-1:0] rsp_entry_count;

   // Shadow copy of the table and the limit register (limit resets to 5)
   logic [KW-1:0] shadow_key [0:DEPTH-1] = '{default: '0};
   logic [TW-1:0] shadow_tag [0:DEPTH-1] = '{default: '0};
   int            shadow_count = 0;
   logic [LW-1:0] shadow_limit = 4'd5;

   topk_result_type pending_results [$];
   int              mismatches     = 0;
   int              results_seen   = 0;
   bit              calm           = 1'b0;

   // Coverage tallies for the summary
   int n_inserts      = 0;
   int n_reads        = 0;
   int n_evictions    = 0;
   int n_turned_away  = 0;
   int n_empty_reads  = 0;
   int n_limit_writes = 0;

   bounded_sorted_top_k_insert u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_entry_key   (req_entry_key),
      .req_entry_tag   (req_entry_tag),
      .req_read_rank   (req_read_rank),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_placed_rank (rsp_placed_rank),
      .rsp_kept        (rsp_kept),
      .rsp_evict_valid (rsp_evict_valid),
      .rsp_evict_key   (rsp_evict_key),
      .rsp_evict_tag   (rsp_evict_tag),
      .rsp_rank_valid  (rsp_rank_valid),
      .rsp_rank_key    (rsp_rank_key),
      .rsp_rank_tag    (rsp_rank_tag),
      .rsp_entry_count (rsp_entry_count)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Apply one item to the shadow table and return what the block should report
   function automatic topk_result_type table_update(input logic cmd,
                                                    input logic [KW-1:0] key,
                                                    input logic [TW-1:0] tag,
                                                    input logic [RW-1:0] rank);
      topk_result_type res;
      logic [KW-1:0]   k [0:DEPTH];
      logic [TW-1:0]   t [0:DEPTH];
      int              pos;
      int              n;
      int              lim;
      res = '0;
      // out-of-range limits clamp to 1..DEPTH
      lim = (shadow_limit == 0) ? 1 : (shadow_limit > DEPTH) ? DEPTH : int'(shadow_limit);
      if (cmd == btk_pkg::CMD_INSERT) begin
         n_inserts++;
         // new entry goes ahead of the first key that is not smaller
         pos = 0;
         while (pos < shadow_count && shadow_key[pos] < key) pos++;
         for (int i = 0; i < pos; i++) begin
            k[i] = shadow_key[i];
            t[i] = shadow_tag[i];
         end
         k[pos] = key;
         t[pos] = tag;
         for (int i = pos; i < shadow_count; i++) begin
            k[i+1] = shadow_key[i];
            t[i+1] = shadow_tag[i];
         end
         n = shadow_count + 1;
         res.placed_rank = CW'(pos);
         res.kept        = 1'b1;
         // over the limit: only the tail drops, even if the limit was lowered a lot
         if (n > lim) begin
            n--;
            res.evict_valid = 1'b1;
            res.evict_key   = k[n];
            res.evict_tag   = t[n];
            n_evictions++;
            if (pos == n) begin
               res.kept = 1'b0;
               n_turned_away++;
            end
         end
         for (int i = 0; i < n; i++) begin
            shadow_key[i] = k[i];
            shadow_tag[i] = t[i];
         end
         shadow_count = n;
      end else begin
         n_reads++;
         if (rank < shadow_count) begin
            res.rank_valid = 1'b1;
            res.rank_key   = shadow_key[rank];
            res.rank_tag   = shadow_tag[rank];
         end else begin
            n_empty_reads++;
         end
      end
      res.entry_count = CW'(shadow_count);
      return res;
   endfunction

   // Flag one differing field; only the first few get printed
   task automatic compare_field(input string fname, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] result %0d %s: expected %h, got %h",
                     $time, results_seen, fname, exp_v, act_v);
      end
   endtask

   // Predict on accepted items and limit writes, check accepted results
   always @(posedge clock) begin : scoreboard
      topk_result_type exp_r;
      topk_result_type pred_r;
      if (!reset) begin
         if (csr_valid && csr_ready)
            shadow_limit = csr_data;
         if (req_valid && req_ready) begin
            pred_r = table_update(req_cmd, req_entry_key, req_entry_tag, req_read_rank);
            pending_results = {pending_results, pred_r};
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] result %0d arrived with nothing pending", $time,
                           results_seen);
            end else begin
               exp_r = pending_results.pop_front();
               compare_field("placed_rank", 32'(exp_r.placed_rank), 32'(rsp_placed_rank));
               compare_field("kept",        32'(exp_r.kept),        32'(rsp_kept));
               compare_field("evict_valid", 32'(exp_r.evict_valid), 32'(rsp_evict_valid));
               compare_field("evict_key",   32'(exp_r.evict_key),   32'(rsp_evict_key));
               compare_field("evict_tag",   32'(exp_r.evict_tag),   32'(rsp_evict_tag));
               compare_field("rank_valid",  32'(exp_r.rank_valid),  32'(rsp_rank_valid));
               compare_field("rank_key",    32'(exp_r.rank_key),    32'(rsp_rank_key));
               compare_field("rank_tag",    32'(exp_r.rank_tag),    32'(rsp_rank_tag));
               compare_field("entry_count", 32'(exp_r.entry_count), 32'(rsp_entry_count));
            end
         end
      end
   end

   // Result side backpressure
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 31);
   end

   // Send one item: optional random gap, then hold it until taken
   task automatic send_item(input logic cmd, input logic [KW-1:0] key,
                            input logic [TW-1:0] tag, input logic [RW-1:0] rank);
      if (!calm && $urandom_range(99) < 31) begin
         do begin
            req_valid <= 1'b0;
            @(posedge clock);
         end while ($urandom_range(99) < 31);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_entry_key <= key;
      req_entry_tag <= tag;
      req_read_rank <= rank;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic insert_entry(input logic [KW-1:0] key, input logic [TW-1:0] tag);
      send_item(btk_pkg::CMD_INSERT, key, tag, RW'($urandom));
   endtask

   task automatic read_rank(input logic [RW-1:0] rank);
      send_item(btk_pkg::CMD_READ, KW'($urandom), TW'($urandom), rank);
   endtask

   // Stop sending and let every outstanding result come back
   task automatic drain();
      req_valid <= 1'b0;
      // first let the last accepted item reach the queue
      @(posedge clock);
      while (pending_results.size() != 0 || rsp_valid) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Limit write, only with the block idle
   task automatic write_limit(input logic [LW-1:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      n_limit_writes++;
   endtask

   // Key mix: many ties and extremes, some copies of stored keys
   function automatic logic [KW-1:0] pick_key();
      case ($urandom_range(9))
         0, 1, 2: return KW'($urandom_range(7));
         3:       return '0;
         4:       return '1;
         5:       return (shadow_count > 0) ? shadow_key[$urandom_range(shadow_count - 1)]
                                            : KW'($urandom);
         default: return KW'($urandom);
      endcase
   endfunction

   // Reads from the empty table after reset
   task automatic test_empty_table();
      read_rank(3'd0);
      read_rank(3'd7);
   endtask

   // Limit 0 behaves as 1: table holds a single entry
   task automatic test_limit_floor();
      write_limit(4'd0);
      insert_entry(16'd10, 16'hAAAA);
      insert_entry(16'd5, 16'h5555);
      insert_entry(16'd20, 16'h1234);
      read_rank(3'd0);
      read_rank(3'd1);
   endtask

   // Ordering, ties (newest first), key and tag extremes, tail eviction
   task automatic test_sorted_insert();
      write_limit(4'd5);
      insert_entry(16'd100, 16'h0001);
      insert_entry(16'd100, 16'h0002);
      insert_entry(16'h0000, 16'hFFFF);
      insert_entry(16'hFFFF, 16'h0000);
      insert_entry(16'd50, 16'h0003);
      insert_entry(16'hFFFF, 16'h0004);
      insert_entry(16'hFFFF, 16'hFFFF);
      read_rank(3'd0);
      read_rank(3'd2);
      read_rank(3'd4);
      read_rank(3'd5);
      read_rank(3'd7);
   endtask

   // Limits above the table depth clamp to the depth
   task automatic test_limit_ceiling();
      write_limit(4'd15);
      insert_entry(16'd7, 16'h0101);
      insert_entry(16'd7, 16'h0202);
      insert_entry(16'd300, 16'h0303);
      insert_entry(16'd1, 16'h0404);
      write_limit(4'd9);
      insert_entry(16'd2, 16'h0505);
      read_rank(3'd7);
   endtask

   // Lowering the limit below the count drops one entry per insert only
   task automatic test_limit_lowered();
      write_limit(4'd2);
      insert_entry(16'd1, 16'h0F0F);
      insert_entry(16'hFFFF, 16'hF0F0);
      read_rank(3'd7);
   endtask

   // Random traffic over several limit settings, one phase without any idling
   task automatic test_random_traffic();
      logic [LW-1:0] limits [0:6];
      limits[0] = 4'd1;
      limits[1] = 4'd8;
      limits[2] = 4'd0;
      limits[3] = 4'd15;
      limits[4] = LW'($urandom_range(15));
      limits[5] = 4'd7;
      limits[6] = LW'($urandom_range(15));
      for (int ph = 0; ph < 7; ph++) begin
         write_limit(limits[ph]);
         calm = (ph == 3);
         repeat (100) begin
            if ($urandom_range(99) < 30)
               send_item(btk_pkg::CMD_READ, KW'($urandom), TW'($urandom), RW'($urandom));
            else
               send_item(btk_pkg::CMD_INSERT, pick_key(), TW'($urandom), RW'($urandom));
         end
      end
      drain();
      calm = 1'b0;
   endtask

   // Main sequence
   initial begin
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_data      = '0;
      req_valid     = 1'b0;
      req_cmd       = btk_pkg::CMD_INSERT;
      req_entry_key = '0;
      req_entry_tag = '0;
      req_read_rank = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_limit_floor();
      test_sorted_insert();
      test_limit_ceiling();
      test_limit_lowered();
      test_random_traffic();

      drain();
      $display("Covered %0d inserts, %0d reads and %0d limit writes, one phase unthrottled.",
               n_inserts, n_reads, n_limit_writes);
      $display("Saw %0d evictions, %0d turned away, %0d empty reads; %0d results checked.",
               n_evictions, n_turned_away, n_empty_reads, results_seen);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Timed out with %0d results outstanding", pending_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
